/* rtl/wllo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllo_pkg - shared types and constants of the window/level overlay unit
// Configuration layout, register indexes, reset values, label colors and the
// payload structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package wllo_pkg;

    // Configuration register indexes, in the order of the register map.
    typedef enum logic [2:0] {
        REG_WINDOW_LOW     = 3'd0,
        REG_WINDOW_HIGH    = 3'd1,
        REG_WINDOW_GAIN    = 3'd2,
        REG_BLEND_OPACITY  = 3'd3,
        REG_SHOW_NECROTIC  = 3'd4,
        REG_SHOW_EDEMA     = 3'd5,
        REG_SHOW_ENHANCING = 3'd6,
        REG_OVERLAY_ENABLE = 3'd7
    } reg_idx_t;

    localparam int CFG_DATA_BITS = 24;
    localparam int WIN_BITS      = 16;
    localparam int GAIN_BITS     = 24;
    localparam int OPACITY_BITS  = 9;
    localparam int GAIN_FRAC     = 16;

    typedef struct packed {
        logic signed [WIN_BITS-1:0] window_low;
        logic signed [WIN_BITS-1:0] window_high;
        logic [GAIN_BITS-1:0]       window_gain;
        logic [OPACITY_BITS-1:0]    blend_opacity;
        logic                       show_necrotic;
        logic                       show_edema;
        logic                       show_enhancing;
        logic                       overlay_enable;
    } cfg_t;

    localparam logic signed [WIN_BITS-1:0] RST_WINDOW_LOW    = 16'sd0;
    localparam logic signed [WIN_BITS-1:0] RST_WINDOW_HIGH   = 16'sd32767;
    localparam logic [GAIN_BITS-1:0]       RST_WINDOW_GAIN   = 24'd510;
    localparam logic [OPACITY_BITS-1:0]    RST_BLEND_OPACITY = 9'd128;
    localparam logic [OPACITY_BITS-1:0]    OPACITY_FULL      = 9'd256;

    // Red sits in the lowest byte so the struct maps straight onto tdata.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    localparam rgb_t COLOR_NONE      = '{blue: 8'd0,  green: 8'd0,   red: 8'd0};
    localparam rgb_t COLOR_NECROTIC  = '{blue: 8'd60, green: 8'd60,  red: 8'd255};
    localparam rgb_t COLOR_EDEMA     = '{blue: 8'd60, green: 8'd220, red: 8'd60};
    localparam rgb_t COLOR_ENHANCING = '{blue: 8'd40, green: 8'd220, red: 8'd255};

    localparam logic [1:0] LABEL_NECROTIC  = 2'd1;
    localparam logic [1:0] LABEL_EDEMA     = 2'd2;
    localparam logic [1:0] LABEL_ENHANCING = 2'd3;

    function automatic rgb_t label_color(input logic [1:0] idx);
        rgb_t c;
        case (idx)
            LABEL_NECROTIC:  c = COLOR_NECROTIC;
            LABEL_EDEMA:     c = COLOR_EDEMA;
            LABEL_ENHANCING: c = COLOR_ENHANCING;
            default:         c = COLOR_NONE;
        endcase
        return c;
    endfunction

    // Window stage result: offset into the window plus overlay decision.
    typedef struct packed {
        logic [WIN_BITS-1:0] offset;
        logic                show;
        logic [1:0]          cidx;
    } win_t;

    // Scale stage result: saturated gray level plus overlay decision.
    typedef struct packed {
        logic [7:0] gray;
        logic       show;
        logic [1:0] cidx;
    } gray_t;

endpackage

/* rtl/wllo_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllo_window - clamp stage
// Clamps the sample to the window, forms its offset from the low bound and
// decides whether the label color is blended in.
// ----------------------------------------------------------------------------
module wllo_window #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wllo_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [7:0]                    in_label,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wllo_pkg::win_t                out_data
);

    localparam int XW = ((SAMPLE_BITS > wllo_pkg::WIN_BITS) ? SAMPLE_BITS
                                                             : wllo_pkg::WIN_BITS) + 1;

    logic signed [XW-1:0] samp_x, low_x, high_x, raised, clamped, diff;
    logic                 above_low;
    logic                 show;
    wllo_pkg::win_t       data_next;
    wllo_pkg::win_t       data_reg;
    logic                 valid_reg;

    always_comb begin
        samp_x    = XW'(in_sample);
        low_x     = XW'(cfg.window_low);
        high_x    = XW'(cfg.window_high);
        raised    = (samp_x < low_x) ? low_x : samp_x;
        clamped   = (raised > high_x) ? high_x : raised;
        above_low = (clamped > low_x);
        diff      = clamped - low_x;
        show      = cfg.overlay_enable &&
                    ((in_label == {6'd0, wllo_pkg::LABEL_NECROTIC} && cfg.show_necrotic) ||
                     (in_label == {6'd0, wllo_pkg::LABEL_EDEMA} && cfg.show_edema) ||
                     (in_label == {6'd0, wllo_pkg::LABEL_ENHANCING} && cfg.show_enhancing));
        data_next.offset = above_low ? diff[wllo_pkg::WIN_BITS-1:0] : '0;
        data_next.show   = show;
        data_next.cidx   = in_label[1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/wllo_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllo_scale - gain multiply and saturate stages
// Multiplies the window offset by the Q8.16 gain, drops the fraction and
// saturates the gray level at 255. Two register stages.
// ----------------------------------------------------------------------------
module wllo_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [23:0]          gain,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wllo_pkg::win_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wllo_pkg::gray_t      out_data
);

    localparam int PROD_BITS = wllo_pkg::WIN_BITS + wllo_pkg::GAIN_BITS;
    localparam int INT_BITS  = PROD_BITS - wllo_pkg::GAIN_FRAC;

    logic [PROD_BITS-1:0] product;
    logic [INT_BITS-1:0]  prod_reg;
    logic                 show_a_reg;
    logic [1:0]           cidx_a_reg;
    logic                 valid_a_reg;
    logic                 ready_a;

    wllo_pkg::gray_t      gray_next;
    wllo_pkg::gray_t      gray_reg;
    logic                 valid_b_reg;
    logic                 ready_b;

    assign product = PROD_BITS'(in_data.offset) * PROD_BITS'(gain);

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a) begin
            prod_reg   <= product[PROD_BITS-1:wllo_pkg::GAIN_FRAC];
            show_a_reg <= in_data.show;
            cidx_a_reg <= in_data.cidx;
        end
    end

    always_comb begin
        gray_next.gray = (|prod_reg[INT_BITS-1:8]) ? 8'hFF : prod_reg[7:0];
        gray_next.show = show_a_reg;
        gray_next.cidx = cidx_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (ready_b) begin
            gray_reg <= gray_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_data  = gray_reg;

    // A stalled result must hold in the saturation stage.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_b_reg && !out_ready) |=> (valid_b_reg && $stable(gray_reg)))
        else $error("scale stage result changed while stalled");

endmodule

/* rtl/wllo_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllo_blend - label color blend and output register
// Blends each channel toward the label color by the opacity, or passes the
// gray level to all three channels.
// ----------------------------------------------------------------------------
module wllo_blend (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [8:0]           opacity,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wllo_pkg::gray_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wllo_pkg::rgb_t       out_data
);

    logic [8:0]      alpha;
    logic [8:0]      keep;
    wllo_pkg::rgb_t  color;
    wllo_pkg::rgb_t  rgb_next;
    wllo_pkg::rgb_t  rgb_reg;
    logic            shown_reg;
    logic            valid_reg;
    logic [16:0]     sum_r, sum_g, sum_b;

    always_comb begin
        alpha = (opacity > wllo_pkg::OPACITY_FULL) ? wllo_pkg::OPACITY_FULL : opacity;
        keep  = wllo_pkg::OPACITY_FULL - alpha;
        color = wllo_pkg::label_color(in_data.cidx);
        sum_r = 17'(in_data.gray) * 17'(keep) + 17'(color.red)   * 17'(alpha);
        sum_g = 17'(in_data.gray) * 17'(keep) + 17'(color.green) * 17'(alpha);
        sum_b = 17'(in_data.gray) * 17'(keep) + 17'(color.blue)  * 17'(alpha);
        if (in_data.show) begin
            rgb_next.red   = sum_r[15:8];
            rgb_next.green = sum_g[15:8];
            rgb_next.blue  = sum_b[15:8];
        end else begin
            rgb_next.red   = in_data.gray;
            rgb_next.green = in_data.gray;
            rgb_next.blue  = in_data.gray;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rgb_reg   <= rgb_next;
            shown_reg <= in_data.show;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

    // A pixel without overlay is plain gray on all channels.
    a_gray_uniform: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !shown_reg) |->
        (rgb_reg.red == rgb_reg.green && rgb_reg.green == rgb_reg.blue))
        else $error("uncolored pixel is not gray");

    // The output register holds its item and overlay flag while stalled.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> ($stable(rgb_reg) && $stable(shown_reg)))
        else $error("output item changed while stalled");

endmodule

/* rtl/window_level_label_overlay_unit.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle while m_tready stays high; each stage holds one item.
// Stages: clamp/offset, gain multiply, saturate, blend/output register.
// Reset: synchronous, active low on aresetn; it empties the pipeline and
// loads every configuration register with its documented default.
// ----------------------------------------------------------------------------
// window_level_label_overlay_unit - window/level mapping with label overlay
// Maps one signed intensity sample and one segmentation label per item to
// one RGB pixel: clamp to window, scale by a reciprocal gain, saturate, and
// alpha-blend toward a fixed label color when the overlay is on.
// ----------------------------------------------------------------------------
module window_level_label_overlay_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Configuration write port; index follows the register map.
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [23:0]                 cfg_wdata,

    // Input channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: sample [SAMPLE_BITS-1:0], zero-padded to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: label [7:0]
    input  logic [7:0]                  s_tuser,

    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: red [7:0], green [15:8], blue [23:16]
    output logic [23:0]                 m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers. Software must write them only while the
    // pipeline is empty, since every stage reads them live; only software enforces this.
    // ------------------------------------------------------------------
    wllo_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_low     <= wllo_pkg::RST_WINDOW_LOW;
            cfg_reg.window_high    <= wllo_pkg::RST_WINDOW_HIGH;
            cfg_reg.window_gain    <= wllo_pkg::RST_WINDOW_GAIN;
            cfg_reg.blend_opacity  <= wllo_pkg::RST_BLEND_OPACITY;
            cfg_reg.show_necrotic  <= 1'b1;
            cfg_reg.show_edema     <= 1'b1;
            cfg_reg.show_enhancing <= 1'b1;
            cfg_reg.overlay_enable <= 1'b0;
        end else if (cfg_we) begin
            case (wllo_pkg::reg_idx_t'(cfg_index))
                wllo_pkg::REG_WINDOW_LOW:
                    cfg_reg.window_low <= cfg_wdata[wllo_pkg::WIN_BITS-1:0];
                wllo_pkg::REG_WINDOW_HIGH:
                    cfg_reg.window_high <= cfg_wdata[wllo_pkg::WIN_BITS-1:0];
                wllo_pkg::REG_WINDOW_GAIN:
                    cfg_reg.window_gain <= cfg_wdata[wllo_pkg::GAIN_BITS-1:0];
                wllo_pkg::REG_BLEND_OPACITY:
                    cfg_reg.blend_opacity <= cfg_wdata[wllo_pkg::OPACITY_BITS-1:0];
                wllo_pkg::REG_SHOW_NECROTIC:  cfg_reg.show_necrotic  <= cfg_wdata[0];
                wllo_pkg::REG_SHOW_EDEMA:     cfg_reg.show_edema     <= cfg_wdata[0];
                wllo_pkg::REG_SHOW_ENHANCING: cfg_reg.show_enhancing <= cfg_wdata[0];
                wllo_pkg::REG_OVERLAY_ENABLE: cfg_reg.overlay_enable <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline. Each stage has its own valid bit and takes a new item
    // whenever it is empty or its successor takes its current one, so
    // bubbles close up; the input stalls only when every stage is full.
    // ------------------------------------------------------------------
    logic                  win_valid, win_ready;
    wllo_pkg::win_t        win_data;
    logic                  gray_valid, gray_ready;
    wllo_pkg::gray_t       gray_data;
    wllo_pkg::rgb_t        rgb_data;

    // Stage 1: clamp the sample into the window and take its offset.
    wllo_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_label  (s_tuser),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .out_data  (win_data)
    );

    // Stages 2 and 3: 16x24 gain multiply, then saturation at 255.
    wllo_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (cfg_reg.window_gain),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_data   (win_data),
        .out_valid (gray_valid),
        .out_ready (gray_ready),
        .out_data  (gray_data)
    );

    // Stage 4: blend toward the label color; this is the output register.
    wllo_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .opacity   (cfg_reg.blend_opacity),
        .in_valid  (gray_valid),
        .in_ready  (gray_ready),
        .in_data   (gray_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb_data)
    );

    assign m_tdata = rgb_data;

    // The result channel comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

/* verif/window_level_label_overlay_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_level_label_overlay_unit_tb - self-checking bench for the overlay unit
// Streams intensity/label items into the unit and checks every RGB pixel
// against a predictor that mirrors the configuration. Directed items cover the
// window, gain, opacity and label corner cases. Random phases then reprogram
// the registers while the unit is idle. Both sides of the stream stall at
// random, and one phase holds the result side off long enough to back up the
// pipeline.
// ----------------------------------------------------------------------------
module window_level_label_overlay_unit_tb;

    localparam int SAMPLE_BITS    = 16;
    localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
    // Longest random gap on either side of the stream, in cycles.
    localparam int STALL_MAX      = 11;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Length of the single long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES    = 80;
    // Quiet cycles at the end, enough for the pipeline to empty.
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 60;
    localparam int BURST_ITEMS    = 48;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [2:0]            cfg_index;
    logic [23:0]           cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata;
    logic [7:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;

    // Copy of the register file as the unit should hold it.
    wllo_pkg::cfg_t shadow_cfg;
    // Predicted pixels, oldest first, one per accepted input item.
    wllo_pkg::rgb_t pixel_queue[$];

    int fail_count     = 0;
    int idle_cycles    = 0;
    // Set by the tests; the result sink clears it once the hold-off is done.
    int rx_hold_cycles = 0;
    bit tx_gaps_on;
    bit rx_stalls_on;

    window_level_label_overlay_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Expected pixel for one sample and label under the current shadow
    // configuration. The clamp raises to the low bound first and lowers to the
    // high bound second, so an inverted window always lands on the high bound
    // and therefore below the low bound, which gives gray level zero.
    function automatic wllo_pkg::rgb_t predict_pixel(
            input logic signed [SAMPLE_BITS-1:0] pix,
            input logic [7:0] lbl);
        longint         lo;
        longint         hi;
        longint         v;
        longint         gray_lvl;
        longint         alpha;
        longint         full;
        wllo_pkg::rgb_t tint;
        wllo_pkg::rgb_t res;
        bit             show;
        lo = $signed(shadow_cfg.window_low);
        hi = $signed(shadow_cfg.window_high);
        v  = pix;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        gray_lvl = 0;
        if (v > lo) begin
            gray_lvl = ((v - lo) * longint'(shadow_cfg.window_gain)) >> wllo_pkg::GAIN_FRAC;
            if (gray_lvl > 255) gray_lvl = 255;
        end
        res.red   = gray_lvl[7:0];
        res.green = gray_lvl[7:0];
        res.blue  = gray_lvl[7:0];

        show = 1'b0;
        tint = wllo_pkg::COLOR_NONE;
        case (lbl)
            {6'd0, wllo_pkg::LABEL_NECROTIC}: begin
                show = shadow_cfg.show_necrotic;
                tint = wllo_pkg::COLOR_NECROTIC;
            end
            {6'd0, wllo_pkg::LABEL_EDEMA}: begin
                show = shadow_cfg.show_edema;
                tint = wllo_pkg::COLOR_EDEMA;
            end
            {6'd0, wllo_pkg::LABEL_ENHANCING}: begin
                show = shadow_cfg.show_enhancing;
                tint = wllo_pkg::COLOR_ENHANCING;
            end
            default: begin
                show = 1'b0;
            end
        endcase

        if (show && shadow_cfg.overlay_enable) begin
            // Opacity codes above full scale saturate to the pure label color.
            full  = longint'(wllo_pkg::OPACITY_FULL);
            alpha = (shadow_cfg.blend_opacity > wllo_pkg::OPACITY_FULL)
                    ? full : longint'(shadow_cfg.blend_opacity);
            res.red   = 8'((gray_lvl * (full - alpha) + longint'(tint.red) * alpha) >> 8);
            res.green = 8'((gray_lvl * (full - alpha) + longint'(tint.green) * alpha) >> 8);
            res.blue  = 8'((gray_lvl * (full - alpha) + longint'(tint.blue) * alpha) >> 8);
        end
        return res;
    endfunction

    // Stream monitor. Both handshakes are sampled right at the clock edge, and
    // the bench drives every input with nonblocking assignments, so the values
    // seen here are the ones the unit registered. The prediction is queued
    // before the output is checked, which keeps the order right even for a
    // pipeline of zero depth.
    always @(posedge aclk) begin : pixel_monitor
        wllo_pkg::rgb_t got;
        wllo_pkg::rgb_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pixel_queue.push_back(predict_pixel(s_tdata[SAMPLE_BITS-1:0], s_tuser));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pixel_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected pixel: r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                    end
                end else begin
                    want = pixel_queue.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"pixel mismatch: expected r=%0d g=%0d b=%0d, ",
                                      "got r=%0d g=%0d b=%0d"},
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink. It draws a fresh stall before every item and honors a
    // long hold-off request from the tests. The wait loop also watches for
    // that request so that a hold-off can begin while no pixel is pending.
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_stalls_on ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && rx_hold_cycles == 0);
        end
    end

    // Offers one item and returns at the edge where it was taken. When the
    // next item follows without a gap, tvalid stays high and is never
    // lowered and raised again in the same step.
    task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] pix,
                              input logic [7:0] lbl);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_BITS'($unsigned(pix));
        s_tuser  <= lbl;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering items and waits until every predicted pixel has come out.
    // At least one edge passes, so a following item never shares this step.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pixel_queue.size() != 0) @(posedge aclk);
    endtask

    // One register write; the shadow copy keeps only the bits the register
    // holds, so junk above the register width must be ignored by the unit.
    task automatic write_reg(input wllo_pkg::reg_idx_t idx,
                             input logic [wllo_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            wllo_pkg::REG_WINDOW_LOW:
                shadow_cfg.window_low = data[wllo_pkg::WIN_BITS-1:0];
            wllo_pkg::REG_WINDOW_HIGH:
                shadow_cfg.window_high = data[wllo_pkg::WIN_BITS-1:0];
            wllo_pkg::REG_WINDOW_GAIN:
                shadow_cfg.window_gain = data[wllo_pkg::GAIN_BITS-1:0];
            wllo_pkg::REG_BLEND_OPACITY:
                shadow_cfg.blend_opacity = data[wllo_pkg::OPACITY_BITS-1:0];
            wllo_pkg::REG_SHOW_NECROTIC:  shadow_cfg.show_necrotic  = data[0];
            wllo_pkg::REG_SHOW_EDEMA:     shadow_cfg.show_edema     = data[0];
            wllo_pkg::REG_SHOW_ENHANCING: shadow_cfg.show_enhancing = data[0];
            wllo_pkg::REG_OVERLAY_ENABLE: shadow_cfg.overlay_enable = data[0];
            default: ;
        endcase
    endtask

    // Reprograms the whole register file. Every item yields a pixel, so an
    // empty prediction queue means the pipeline is empty as well.
    task automatic program_config(input logic signed [wllo_pkg::WIN_BITS-1:0] lo,
                                  input logic signed [wllo_pkg::WIN_BITS-1:0] hi,
                                  input logic [wllo_pkg::GAIN_BITS-1:0] gain,
                                  input logic [wllo_pkg::OPACITY_BITS-1:0] opacity,
                                  input bit nec, input bit ede, input bit enh,
                                  input bit ovl);
        wait_for_drain();
        write_reg(wllo_pkg::REG_WINDOW_LOW,     {8'($urandom), lo});
        write_reg(wllo_pkg::REG_WINDOW_HIGH,    {8'($urandom), hi});
        write_reg(wllo_pkg::REG_WINDOW_GAIN,    gain);
        write_reg(wllo_pkg::REG_BLEND_OPACITY,  {15'($urandom), opacity});
        write_reg(wllo_pkg::REG_SHOW_NECROTIC,  {23'($urandom), nec});
        write_reg(wllo_pkg::REG_SHOW_EDEMA,     {23'($urandom), ede});
        write_reg(wllo_pkg::REG_SHOW_ENHANCING, {23'($urandom), enh});
        write_reg(wllo_pkg::REG_OVERLAY_ENABLE, {23'($urandom), ovl});
        cfg_we <= 1'b0;
    endtask

    // Reset values: full positive window, overlay off, so labels do nothing.
    task automatic test_reset_defaults();
        send_pixel(16'sh8000, 8'd1);
        send_pixel(16'sh0000, 8'd2);
        send_pixel(16'sh0080, 8'd3);
        send_pixel(16'sh7fff, 8'd0);
    endtask

    // Widest window, an inverted window, zero gain and the largest gain.
    task automatic test_window_extremes();
        program_config(16'sh8000, 16'sh7fff, 24'd255, wllo_pkg::RST_BLEND_OPACITY,
                       1, 1, 1, 0);
        send_pixel(16'sh8000, 8'd0);
        send_pixel(16'sh7fff, 8'd0);
        send_pixel(16'sh0000, 8'd0);

        program_config(16'sd100, -16'sd100, 24'd65536, wllo_pkg::RST_BLEND_OPACITY,
                       1, 1, 1, 0);
        send_pixel(16'sh8000, 8'd0);
        send_pixel(16'sh0000, 8'd0);
        send_pixel(16'sh7fff, 8'd0);

        // Zero gain keeps gray at black, with and without a blended label.
        program_config(16'sh0000, 16'sh7fff, 24'd0, wllo_pkg::RST_BLEND_OPACITY,
                       1, 1, 1, 1);
        send_pixel(16'sh7fff, 8'd0);
        send_pixel(16'sh7fff, 8'd2);

        program_config(16'sh0000, 16'sh7fff, 24'hffffff, wllo_pkg::RST_BLEND_OPACITY,
                       1, 1, 1, 0);
        send_pixel(16'sh0001, 8'hff);
        send_pixel(16'shffff, 8'd0);
    endtask

    // Every label class, the show bits, and opacity at zero, full scale and
    // above full scale.
    task automatic test_label_blend();
        program_config(-16'sd1000, 16'sd1000, 24'd8355, 9'd128, 1, 1, 1, 1);
        send_pixel(16'sd0, 8'd0);
        send_pixel(16'sd200, 8'd1);
        send_pixel(-16'sd500, 8'd2);
        send_pixel(16'sd999, 8'd3);
        send_pixel(16'sd300, 8'd4);
        send_pixel(16'sd300, 8'd255);

        program_config(-16'sd1000, 16'sd1000, 24'd8355, 9'd511, 1, 0, 1, 1);
        send_pixel(16'sd100, 8'd1);
        send_pixel(16'sd100, 8'd2);

        program_config(-16'sd1000, 16'sd1000, 24'd8355, 9'd0, 0, 1, 1, 1);
        send_pixel(16'sd700, 8'd1);
        send_pixel(16'sd700, 8'd3);

        program_config(-16'sd1000, 16'sd1000, 24'd8355, wllo_pkg::OPACITY_FULL,
                       1, 1, 1, 1);
        send_pixel(-16'sd900, 8'd3);
    endtask

    // Random register settings, each followed by a run of random items. Most
    // phases use a window with a matched gain so gray levels span the whole
    // range; some use inverted windows, zero gain or a wild gain. Labels are
    // mostly the interesting classes, the rest random bytes.
    task automatic test_random_phases();
        logic signed [wllo_pkg::WIN_BITS-1:0] lo;
        logic signed [wllo_pkg::WIN_BITS-1:0] hi;
        logic signed [wllo_pkg::WIN_BITS-1:0] a;
        logic signed [wllo_pkg::WIN_BITS-1:0] b;
        logic signed [wllo_pkg::WIN_BITS-1:0] pix;
        logic [wllo_pkg::GAIN_BITS-1:0]       gain;
        logic [wllo_pkg::OPACITY_BITS-1:0]    opacity;
        logic [7:0]                           lbl;
        int                                   mode;
        int                                   span;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            a    = wllo_pkg::WIN_BITS'($urandom);
            b    = wllo_pkg::WIN_BITS'($urandom);
            mode = $urandom_range(0, 9);
            lo   = (a < b) ? a : b;
            hi   = (a < b) ? b : a;
            span = int'(hi) - int'(lo);
            gain = (span == 0)
                   ? wllo_pkg::GAIN_BITS'($urandom)
                   : wllo_pkg::GAIN_BITS'((255 * 65536) / span + $urandom_range(0, 3));
            if (mode == 0) begin
                lo = (a < b) ? b : a;
                hi = (a < b) ? a : b;
            end else if (mode == 1) begin
                gain = '0;
            end else if (mode == 2) begin
                gain = wllo_pkg::GAIN_BITS'($urandom);
            end
            opacity = ($urandom_range(0, 3) == 0)
                      ? wllo_pkg::OPACITY_BITS'($urandom_range(257, 511))
                      : wllo_pkg::OPACITY_BITS'($urandom_range(0, 256));
            // Some phases run with no gaps on one side or the other.
            tx_gaps_on   = (phase % 4) != 3;
            rx_stalls_on = (phase % 5) != 4;
            program_config(lo, hi, gain, opacity, 1'($urandom), 1'($urandom),
                           1'($urandom), $urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                lbl = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
                if (lo <= hi && $urandom_range(0, 1) == 1) begin
                    pix = wllo_pkg::WIN_BITS'(int'(lo) + int'($urandom_range(0, span)));
                end else begin
                    pix = wllo_pkg::WIN_BITS'($urandom);
                end
                send_pixel(pix, lbl);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while items keep coming with no
    // gaps, so the pipeline fills and s_tready must drop. Afterwards the
    // sender pauses until every pixel has been delivered.
    task automatic test_backpressure();
        program_config(-16'sd2000, 16'sd6000, 24'd2088, 9'd200, 1, 1, 1, 1);
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            send_pixel(wllo_pkg::WIN_BITS'($urandom_range(0, 9000) - 2500),
                       8'($urandom_range(0, 4)));
        end
        wait_for_drain();
        tx_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= wllo_pkg::REG_WINDOW_LOW;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        shadow_cfg = '{window_low:     wllo_pkg::RST_WINDOW_LOW,
                       window_high:    wllo_pkg::RST_WINDOW_HIGH,
                       window_gain:    wllo_pkg::RST_WINDOW_GAIN,
                       blend_opacity:  wllo_pkg::RST_BLEND_OPACITY,
                       show_necrotic:  1'b1,
                       show_edema:     1'b1,
                       show_enhancing: 1'b1,
                       overlay_enable: 1'b0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_window_extremes();
        test_label_blend();
        test_random_phases();
        test_backpressure();

        // Let any stray pixel show up before the verdict.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pixel_queue.size() != 0) fail_count++;

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
